[sv/depth_tested_triangle_raster_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the depth tested triangle rasterizer
// Shorthand for clocked implication checks, with reset masking.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TESTED_TRIANGLE_RASTER_DEFINES_SVH
`define DEPTH_TESTED_TRIANGLE_RASTER_DEFINES_SVH

// same-cycle implication
`define DTR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DTR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/dtr_pkg.sv]
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared constants, widths and helpers of the triangle rasterizer.
// ----------------------------------------------------------------------------
package dtr_pkg;

   localparam int TILE_WIDTH  = 8;
   localparam int TILE_HEIGHT = 8;

   // coordinate and index widths
   localparam int XW   = $clog2(TILE_WIDTH);
   localparam int YW   = $clog2(TILE_HEIGHT);
   localparam int NPIX = TILE_WIDTH * TILE_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   // signed width of edge terms (differences and cross products)
   localparam int NW   = XW + YW + 3;

   // weights: 16 fractional bits, up to 1.0 inclusive
   localparam int FRAC = 16;
   localparam int QW   = FRAC + 1;
   localparam int ACCW = 36;

   localparam logic signed [15:0] DEPTH_FAR = 16'sh8000;

   // map signed Q1.15 to pixel position: ((v + 32768) * size) >> 16
   function automatic logic [7:0] to_pix(input logic signed [15:0] v, input int size);
      logic [23:0] p;
      p = 24'({~v[15], v[14:0]}) * 24'(size);
      return p[23:16];
   endfunction

endpackage

[sv/depth_tested_triangle_raster.sv]
// ----------------------------------------------------------------------------
// depth_tested_triangle_raster
// Rasterizes one triangle per input word into an 8x8 tile with depth test.
// ----------------------------------------------------------------------------
// One triangle is taken at a time and req_tready stays low until its last
// result has been handed to the output register. After setup, every pixel of
// the bounding box gets an edge test, and each inside pixel then runs the
// sequential divider (17 steps) twice (w1, w2), the shared multiplier three
// times for depth and a depth compare; a kept pixel takes one more state to
// be stored. A triangle spanning the whole tile has at most 36 inside pixels.
// Every kept pixel is one result word; a triangle that keeps none gives one
// word with written low. tlast marks the final word.
// ----------------------------------------------------------------------------
`include "depth_tested_triangle_raster_defines.svh"

module depth_tested_triangle_raster
   import dtr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
   // vert2_x, vert2_y, vert2_z, fill_color
   input  logic [175:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pix_x, pix_y, pix_color, pix_depth, two zero pad bits
   output logic [55:0]  rsp_tdata,
   // written
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_EDGE   = 4'd2;
   localparam logic [3:0] S_DIV1   = 4'd3;
   localparam logic [3:0] S_DIV2   = 4'd4;
   localparam logic [3:0] S_MAC0   = 4'd5;
   localparam logic [3:0] S_MAC1   = 4'd6;
   localparam logic [3:0] S_MAC2   = 4'd7;
   localparam logic [3:0] S_MAC3   = 4'd8;
   localparam logic [3:0] S_DEPTH  = 4'd9;
   localparam logic [3:0] S_KEEP   = 4'd10;
   localparam logic [3:0] S_NEXT   = 4'd11;
   localparam logic [3:0] S_FINISH = 4'd12;

   logic [3:0] state_ff, state_in;

   // triangle registers
   logic [XW-1:0]      x0_ff, x1_ff, x2_ff;
   logic [YW-1:0]      y0_ff, y1_ff, y2_ff;
   logic signed [15:0] z0_ff, z1_ff, z2_ff;
   logic [31:0]        color_ff;
   logic [XW-1:0]      xmin_ff, xmax_ff, px_ff, px_in;
   logic [YW-1:0]      ymax_ff, py_ff, py_in;
   logic signed [NW-1:0] ax_ff, ay_ff, bx_ff, by_ff, d_ff;
   logic signed [NW-1:0] n1_ff, n2_ff;
   logic [QW-1:0]      w1_ff, w2_ff;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [ACCW-1:0] prod_ff, prod_in;
   logic signed [15:0] znew_ff;

   // pending kept pixel (held back until its last flag is known)
   logic               pend_v_ff, pend_v_in;
   logic [XW-1:0]      pend_x_ff;
   logic [YW-1:0]      pend_y_ff;
   logic signed [15:0] pend_z_ff;

   // output register
   logic               out_v_ff, out_v_in;
   logic [2:0]         out_x_ff, out_y_ff;
   logic [31:0]        out_c_ff;
   logic signed [15:0] out_z_ff;
   logic               out_w_ff, out_l_ff;
   logic               out_load, out_free;
   logic               out_w_in, out_l_in;
   logic [2:0]         out_x_in, out_y_in;
   logic [31:0]        out_c_in;
   logic signed [15:0] out_z_in;

   // accept: map vertices to pixels
   logic [XW-1:0] vx0, vx1, vx2;
   logic [YW-1:0] vy0, vy1, vy2;
   assign vx0 = XW'(to_pix(req_tdata[15:0],    TILE_WIDTH));
   assign vy0 = YW'(to_pix(req_tdata[31:16],   TILE_HEIGHT));
   assign vx1 = XW'(to_pix(req_tdata[63:48],   TILE_WIDTH));
   assign vy1 = YW'(to_pix(req_tdata[79:64],   TILE_HEIGHT));
   assign vx2 = XW'(to_pix(req_tdata[111:96],  TILE_WIDTH));
   assign vy2 = YW'(to_pix(req_tdata[127:112], TILE_HEIGHT));

   // setup: edge vectors, area and bounding box
   logic signed [NW-1:0] sax, say, sbx, sby, e_val;
   logic [XW-1:0] bxmin, bxmax;
   logic [YW-1:0] bymin, bymax;
   always_comb begin
      sax   = NW'(x1_ff) - NW'(x0_ff);
      say   = NW'(y1_ff) - NW'(y0_ff);
      sbx   = NW'(x2_ff) - NW'(x0_ff);
      sby   = NW'(y2_ff) - NW'(y0_ff);
      e_val = sax * sby - sbx * say;
      bxmin = (x0_ff < x1_ff) ? x0_ff : x1_ff;
      bxmin = (bxmin < x2_ff) ? bxmin : x2_ff;
      bxmax = (x0_ff > x1_ff) ? x0_ff : x1_ff;
      bxmax = (bxmax > x2_ff) ? bxmax : x2_ff;
      bymin = (y0_ff < y1_ff) ? y0_ff : y1_ff;
      bymin = (bymin < y2_ff) ? bymin : y2_ff;
      bymax = (y0_ff > y1_ff) ? y0_ff : y1_ff;
      bymax = (bymax > y2_ff) ? bymax : y2_ff;
   end

   // edge terms for the current pixel, sign-corrected to d > 0
   logic signed [NW-1:0] cx, cy, en1, en2;
   logic                 in_tri;
   always_comb begin
      cx  = NW'(px_ff) - NW'(x0_ff);
      cy  = NW'(py_ff) - NW'(y0_ff);
      en1 = bx_ff * cy - cx * by_ff;
      en2 = cx * ay_ff - ax_ff * cy;
      if (d_ff < 0) begin
         en1 = -en1;
         en2 = -en2;
      end
      in_tri = !en1[NW-1] && !en2[NW-1] && ((en1 + en2) <= (d_ff < 0 ? -d_ff : d_ff));
   end

   // shared divider
   logic          div_start, div_busy, div_done;
   logic [NW-1:0] div_num, div_den;
   logic [QW-1:0] div_q;
   assign div_den = (d_ff < 0) ? NW'(-d_ff) : NW'(d_ff);

   dtr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   // depth store
   logic [AW-1:0]      idx;
   logic signed [15:0] zrd;
   logic               zwr;
   assign idx = AW'(int'(py_ff) * TILE_WIDTH + int'(px_ff));

   dtr_zbuf u_zbuf (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx),
      .rd_data (zrd),
      .wr_en   (zwr),
      .wr_addr (idx),
      .wr_data (znew_ff)
   );

   // shared multiplier operands
   logic signed [QW:0]  mul_w;
   logic signed [15:0]  mul_z;
   logic [QW:0]         w0;
   assign w0 = (QW+1)'(1 << FRAC) - {1'b0, w1_ff} - {1'b0, w2_ff};

   always_comb begin
      case (state_ff)
         S_MAC0:  begin mul_w = $signed(w0);            mul_z = z0_ff; end
         S_MAC1:  begin mul_w = $signed({1'b0, w1_ff}); mul_z = z1_ff; end
         default: begin mul_w = $signed({1'b0, w2_ff}); mul_z = z2_ff; end
      endcase
      prod_in = ACCW'(mul_w) * ACCW'(mul_z);
   end

   // depth: truncate toward zero, saturate
   logic signed [ACCW-FRAC-1:0] zq;
   logic signed [15:0]          zsat;
   always_comb begin
      zq = acc_ff[ACCW-1:FRAC];
      if (acc_ff[ACCW-1] && (acc_ff[FRAC-1:0] != '0)) begin
         zq = zq + 1'b1;
      end
      if (zq > 32767) begin
         zsat = 16'sd32767;
      end else if (zq < -32768) begin
         zsat = DEPTH_FAR;
      end else begin
         zsat = zq[15:0];
      end
   end

   assign out_free = !out_v_ff || rsp_tready;
   logic last_px;
   assign last_px = (px_ff == xmax_ff) && (py_ff == ymax_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = n1_ff;
      zwr       = 1'b0;
      out_load  = 1'b0;
      out_w_in  = 1'b1;
      out_l_in  = 1'b0;
      out_x_in  = 3'(pend_x_ff);
      out_y_in  = 3'(pend_y_ff);
      out_c_in  = color_ff;
      out_z_in  = pend_z_ff;
      pend_v_in = pend_v_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      acc_in    = acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            px_in = bxmin;
            py_in = bymin;
            state_in = (e_val == '0) ? S_FINISH : S_EDGE;
         end
         S_EDGE: begin
            if (in_tri) begin
               div_start = 1'b1;
               div_num   = en1;
               state_in  = S_DIV1;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = n2_ff;
               state_in  = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               state_in = S_MAC0;
            end
         end
         S_MAC0: state_in = S_MAC1;
         S_MAC1: begin
            acc_in   = prod_ff;
            state_in = S_MAC2;
         end
         S_MAC2: begin
            acc_in   = acc_ff + prod_ff;
            state_in = S_MAC3;
         end
         S_MAC3: begin
            acc_in   = acc_ff + prod_ff;
            state_in = S_DEPTH;
         end
         S_DEPTH: begin
            state_in = (zsat > zrd) ? S_KEEP : S_NEXT;
         end
         S_KEEP: begin
            if (!pend_v_ff || out_free) begin
               zwr       = 1'b1;
               out_load  = pend_v_ff;
               pend_v_in = 1'b1;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (last_px) begin
               state_in = S_FINISH;
            end else if (px_ff == xmax_ff) begin
               px_in    = xmin_ff;
               py_in    = py_ff + 1'b1;
               state_in = S_EDGE;
            end else begin
               px_in    = px_ff + 1'b1;
               state_in = S_EDGE;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_l_in  = 1'b1;
               pend_v_in = 1'b0;
               if (!pend_v_ff) begin
                  out_w_in = 1'b0;
                  out_x_in = '0;
                  out_y_in = '0;
                  out_c_in = '0;
                  out_z_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_v_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_v_ff);
   end

   assign req_tready = (state_ff == S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         x0_ff    <= vx0;
         y0_ff    <= vy0;
         z0_ff    <= req_tdata[47:32];
         x1_ff    <= vx1;
         y1_ff    <= vy1;
         z1_ff    <= req_tdata[95:80];
         x2_ff    <= vx2;
         y2_ff    <= vy2;
         z2_ff    <= req_tdata[143:128];
         color_ff <= req_tdata[175:144];
      end
      if (state_ff == S_SETUP) begin
         ax_ff   <= sax;
         ay_ff   <= say;
         bx_ff   <= sbx;
         by_ff   <= sby;
         d_ff    <= -e_val;
         xmin_ff <= bxmin;
         xmax_ff <= bxmax;
         ymax_ff <= bymax;
      end
      if (state_ff == S_EDGE) begin
         n1_ff <= en1;
         n2_ff <= en2;
      end
      if (state_ff == S_DIV1 && div_done) begin
         w1_ff <= div_q;
      end
      if (state_ff == S_DIV2 && div_done) begin
         w2_ff <= div_q;
      end
      if (state_ff == S_DEPTH) begin
         znew_ff <= zsat;
      end
      if (zwr) begin
         pend_x_ff <= px_ff;
         pend_y_ff <= py_ff;
         pend_z_ff <= znew_ff;
      end
      if (out_load) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_c_ff <= out_c_in;
         out_z_ff <= out_z_in;
         out_w_ff <= out_w_in;
         out_l_ff <= out_l_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_z_ff, out_c_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_w_ff;
   assign rsp_tlast  = out_l_ff;

   // checks
   `DTR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `DTR_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast)
   `DTR_ASSERT_NOW(a_div_idle_on_start, clock, reset, div_start, !div_busy)
   `DTR_ASSERT_NOW(a_no_overwrite, clock, reset, out_load && !rsp_tready, !out_v_ff)

endmodule

[sv/dtr_div.sv]
// ----------------------------------------------------------------------------
// dtr_div
// Restoring divider, one quotient bit per cycle: q = floor(num * 2^16 / den)
// for 0 <= num <= den, den > 0. Seventeen steps.
// ----------------------------------------------------------------------------
module dtr_div
   import dtr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NW-1:0]         num,
   input  logic [NW-1:0]         den,
   output logic                  busy,
   output logic                  done,
   output logic [QW-1:0]         quot
);

   localparam int CNTW = $clog2(QW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW:0]     rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [NW:0]     trial;

   // one compare and subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      trial   = (cnt_ff == '0) ? rem_ff : {rem_ff[NW-1:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num};
         q_in    = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = trial - {1'b0, den};
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

[sv/dtr_zbuf.sv]
// ----------------------------------------------------------------------------
// dtr_zbuf
// Depth store for the tile: one write and one registered read per cycle.
// Per-entry valid bits make a never-written entry read as farthest depth.
// ----------------------------------------------------------------------------
module dtr_zbuf
   import dtr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [AW-1:0]           rd_addr,
   output logic signed [15:0]      rd_data,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic signed [15:0]      wr_data
);

   logic signed [15:0] mem [NPIX];
   logic [NPIX-1:0]    valid_ff;
   logic signed [15:0] mem_rd_ff;
   logic               rd_valid_ff;

   // storage and read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? mem_rd_ff : DEPTH_FAR;

endmodule

[bench/depth_tested_triangle_raster_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for depth_tested_triangle_raster
// Sends triangles into the tile rasterizer and checks every pixel word it
// returns against a built-in predictor that keeps its own depth store.
// ----------------------------------------------------------------------------

module depth_tested_triangle_raster_tb
   import dtr_pkg::*;
();

   // one triangle as sent on req_tdata
   typedef struct {
      logic signed [15:0] vx [3];
      logic signed [15:0] vy [3];
      logic signed [15:0] vz [3];
      logic [31:0]        color;
   } tri_type;

   // one expected pixel word
   typedef struct {
      logic [2:0]         px;
      logic [2:0]         py;
      logic [31:0]        color;
      logic signed [15:0] depth;
      logic               written;
      logic               last;
   } pixel_type;

   // ------------------------------------------------------------------------
   // scoreboard: depth store model and queue of pending pixel words
   // ------------------------------------------------------------------------
   class scoreboard_type;
      logic signed [15:0] zbuf [NPIX];
      pixel_type          pending [$];
      int                 errors;
      int                 kept;
      int                 empty;

      function new();
         foreach (zbuf[i]) zbuf[i] = DEPTH_FAR;
         errors = 0;
         kept   = 0;
         empty  = 0;
      endfunction

      function automatic longint pix_of(logic signed [15:0] v, int size);
         return ((longint'(v) + 32768) * size) >>> 16;
      endfunction

      // rasterize one triangle and queue its pixel words
      function void note_triangle(tri_type t);
         longint x [3], y [3], z [3];
         longint ax, ay, bx, by, e, cx, cy, n1, n2, d, w0, w1, w2, acc, zz;
         longint xmin, xmax, ymin, ymax;
         int     cnt, idx;
         pixel_type p;
         cnt = 0;
         for (int k = 0; k < 3; k++) begin
            x[k] = pix_of(t.vx[k], TILE_WIDTH);
            y[k] = pix_of(t.vy[k], TILE_HEIGHT);
            z[k] = t.vz[k];
         end
         ax = x[1] - x[0]; bx = x[2] - x[0];
         ay = y[1] - y[0]; by = y[2] - y[0];
         e  = ax * by - bx * ay;
         if (e != 0) begin
            xmin = x[0]; xmax = x[0]; ymin = y[0]; ymax = y[0];
            for (int k = 1; k < 3; k++) begin
               if (x[k] < xmin) xmin = x[k];
               if (x[k] > xmax) xmax = x[k];
               if (y[k] < ymin) ymin = y[k];
               if (y[k] > ymax) ymax = y[k];
            end
            for (longint yy = ymin; yy <= ymax; yy++) begin
               for (longint xx = xmin; xx <= xmax; xx++) begin
                  cx = xx - x[0]; cy = yy - y[0];
                  n1 = bx * cy - cx * by;
                  n2 = cx * ay - ax * cy;
                  d  = -e;
                  if (d < 0) begin
                     d = -d; n1 = -n1; n2 = -n2;
                  end
                  if (n1 < 0 || n2 < 0 || n1 + n2 > d) continue;
                  // integer division truncates toward zero
                  w1  = (n1 * 65536) / d;
                  w2  = (n2 * 65536) / d;
                  w0  = 65536 - w1 - w2;
                  acc = w0 * z[0] + w1 * z[1] + w2 * z[2];
                  zz  = acc / 65536;
                  if (zz > 32767) zz = 32767;
                  if (zz < -32768) zz = -32768;
                  idx = int'(yy * TILE_WIDTH + xx);
                  if (longint'(zbuf[idx]) >= zz) continue;
                  zbuf[idx]  = 16'(zz);
                  p.px       = 3'(xx);
                  p.py       = 3'(yy);
                  p.color    = t.color;
                  p.depth    = 16'(zz);
                  p.written  = 1'b1;
                  p.last     = 1'b0;
                  pending.push_back(p);
                  cnt++;
               end
            end
         end
         if (cnt == 0) begin
            p = '{px: 0, py: 0, color: 0, depth: 0, written: 0, last: 1};
            pending.push_back(p);
            empty++;
         end else begin
            pending[pending.size() - 1].last = 1'b1;
            kept += cnt;
         end
      endfunction

      // compare one received word with the oldest expectation
      function void check_pixel(pixel_type got);
         pixel_type exp;
         if (pending.size() == 0) begin
            $error("unexpected pixel word x=%0d y=%0d", got.px, got.py);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.px !== exp.px) begin
            $error("pix_x: expected %0d, got %0d", exp.px, got.px); errors++;
         end
         if (got.py !== exp.py) begin
            $error("pix_y: expected %0d, got %0d", exp.py, got.py); errors++;
         end
         if (got.color !== exp.color) begin
            $error("pix_color: expected %h, got %h", exp.color, got.color); errors++;
         end
         if (got.depth !== exp.depth) begin
            $error("pix_depth: expected %0d, got %0d", exp.depth, got.depth); errors++;
         end
         if (got.written !== exp.written) begin
            $error("written: expected %0d, got %0d", exp.written, got.written); errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG = 200000;

   logic         clock;
   logic         reset;
   logic [175:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;

   scoreboard_type   sb;
   int               idle_cycles;
   int               tri_sent;
   bit               stall_on;

   depth_tested_triangle_raster i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: stall pattern with calm stretches, check each accepted word
   always @(posedge clock) begin
      pixel_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.px      = rsp_tdata[2:0];
            got.py      = rsp_tdata[5:3];
            got.color   = rsp_tdata[37:6];
            got.depth   = rsp_tdata[53:38];
            got.written = rsp_tuser[0];
            got.last    = rsp_tlast;
            sb.check_pixel(got);
         end
         if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
         rsp_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic logic [175:0] pack_tri(tri_type t);
      return {t.color, t.vz[2], t.vy[2], t.vx[2], t.vz[1], t.vy[1], t.vx[1],
              t.vz[0], t.vy[0], t.vx[0]};
   endfunction

   // drive one triangle and wait for its handshake; valid stays up for a burst
   task automatic send_tri(tri_type t);
      req_tdata  <= pack_tri(t);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_triangle(t);
      tri_sent++;
   endtask

   // random gap between bursts
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic tri_type make_tri(logic signed [15:0] x0, logic signed [15:0] y0,
                                        logic signed [15:0] z0, logic signed [15:0] x1,
                                        logic signed [15:0] y1, logic signed [15:0] z1,
                                        logic signed [15:0] x2, logic signed [15:0] y2,
                                        logic signed [15:0] z2, logic [31:0] c);
      tri_type t;
      t.vx = '{x0, x1, x2}; t.vy = '{y0, y1, y2}; t.vz = '{z0, z1, z2};
      t.color = c;
      return t;
   endfunction

   // random triangle: mostly small ones around a random centre, some wild
   function automatic tri_type rand_tri();
      tri_type t;
      int   cx, cy, r;
      cx = $urandom_range(0, 65535) - 32768;
      cy = $urandom_range(0, 65535) - 32768;
      r  = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(4096, 24576);
      for (int k = 0; k < 3; k++) begin
         if (r == 65535) begin
            t.vx[k] = 16'($urandom);
            t.vy[k] = 16'($urandom);
         end else begin
            t.vx[k] = 16'(cx + $urandom_range(0, r) - r / 2);
            t.vy[k] = 16'(cy + $urandom_range(0, r) - r / 2);
         end
         t.vz[k] = 16'($urandom);
      end
      t.color = $urandom;
      return t;
   endfunction

   initial begin
      tri_type t;
      sb          = new();
      stall_on    = 1'b0;
      tri_sent    = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full tile, tie, nearer redraw, farther redraw, degenerate cases
      send_tri(make_tri(-16'sd32768, -16'sd32768, 16'sd0, 16'sd32767, -16'sd32768,
                        16'sd0, -16'sd32768, 16'sd32767, 16'sd0, 32'hFFFF_FFFF));
      send_tri(make_tri(-16'sd32768, -16'sd32768, 16'sd0, 16'sd32767, -16'sd32768,
                        16'sd0, -16'sd32768, 16'sd32767, 16'sd0, 32'h1234_5678));
      send_tri(make_tri(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                        16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 32'h0));
      send_tri(make_tri(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                        16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 32'hA5A5_5A5A));
      // zero area: all on one point, then collinear
      send_tri(make_tri(16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd100,
                        16'sd0, 16'sd0, 16'sd100, 32'h5555_AAAA));
      send_tri(make_tri(-16'sd32768, -16'sd32768, 16'sd5, 16'sd0, 16'sd0, 16'sd5,
                        16'sd32767, 16'sd32767, 16'sd5, 32'hDEAD_BEEF));
      // single-row triangle of zero area, and far depth that is never kept
      send_tri(make_tri(-16'sd32768, 16'sd0, 16'sd32767, 16'sd32767, 16'sd0,
                        -16'sd32768, 16'sd0, 16'sd4096, 16'sd0, 32'h0F0F_0F0F));
      send_tri(make_tri(-16'sd20000, -16'sd20000, -16'sd32768, 16'sd20000, -16'sd20000,
                        -16'sd32768, 16'sd0, 16'sd20000, -16'sd32768, 32'h8000_0001));
      send_tri(make_tri(16'sh7FFF, 16'sh5555, 16'shAAAA, 16'sh5555, 16'sh8000,
                        16'sh7FFF, 16'sh8000, 16'shAAAA, 16'sh5555, 32'h7FFF_FFFE));

      // hold off until the block has drained
      wait_drained();

      // random bursts
      while (tri_sent < 130) begin
         int burst;
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst; b++) send_tri(rand_tri());
         if (tri_sent > 60 && tri_sent < 70) wait_drained();
         idle_gap();
      end

      wait_drained();
      repeat (100) @(posedge clock);
      $display("Sent %0d triangles: %0d pixels kept, %0d with nothing drawn.",
               tri_sent, sb.kept, sb.empty);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
